@@ rtl/core/vpri_pkg.sv @@
// Shared operation codes, access codes and constants of the video port register interface.
package vpri_pkg;

  typedef enum logic [2:0] {
    OP_CTRL_WR   = 3'd0,
    OP_CTRL_RD   = 3'd1,
    OP_DATA_WR   = 3'd2,
    OP_DATA_RD   = 3'd3,
    OP_LINE_TICK = 3'd4
  } op_e;

  // Access codes latched by the second control byte.
  localparam logic [1:0] CODE_VRAM_READ  = 2'd0;
  localparam logic [1:0] CODE_VRAM_WRITE = 2'd1;
  localparam logic [1:0] CODE_REG_WRITE  = 2'd2;
  localparam logic [1:0] CODE_COLOUR     = 2'd3;

  localparam int unsigned NUM_MODE_REGS = 16;
  localparam logic [3:0]  REG_MODE0       = 4'd0;
  localparam logic [3:0]  REG_MODE1       = 4'd1;
  localparam logic [3:0]  REG_LINE_RELOAD = 4'd10;

  localparam int unsigned MODE0_LINE_IE_BIT  = 4;
  localparam int unsigned MODE1_FRAME_IE_BIT = 5;
  localparam int unsigned STATUS_FRAME_BIT   = 7;

  localparam logic [8:0] LINE_FRAME_IRQ  = 9'h0C1;
  localparam logic [8:0] LINE_ACTIVE_END = 9'd192;
  localparam logic [7:0] LINE_COUNT_INIT = 8'hFF;

endpackage

@@ rtl/core/video_port_register_interface.sv @@
// Top level of the video port register interface: command latch, video memory and interrupts.
//
// The block takes one host operation or scanline tick per item and returns one result item
// per input item. After reset it first clears the video memory, one entry per cycle; no
// item is accepted during that pass. From then on an item is accepted in every cycle in
// which the output register is empty or being drained, so the sustained rate is one item
// per clock while the output is drained. The single read port of the video memory sets the
// timing: a prefetch issued by a data read or by a read-setup command passes through the
// memory output register into the read buffer register, and a data read that follows at
// once takes its value straight from the memory output. The colour memory is never read
// back through this port and pixel output is not built, so no colour store is kept here; a
// data write with the colour access code only advances the address.
module video_port_register_interface #(
  parameter int unsigned ADDR_BITS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] data_i,
  input  logic [8:0] line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_value_o,
  output logic       irq_o
);

  localparam int unsigned HiW   = ADDR_BITS - 8;
  localparam int unsigned Depth = 1 << ADDR_BITS;

  logic                 in_fire;
  vpri_pkg::op_e        op;

  logic [ADDR_BITS-1:0] addr_q, addr_d, addr_new;
  logic [1:0]           code_q, code_d;
  logic                 second_q, second_d;
  logic [7:0]           rbuf_q, rbuf_now;
  logic                 frame_q, frame_d;
  logic [7:0]           line_cnt_q, line_cnt_d;
  logic [7:0]           mode_q [vpri_pkg::NUM_MODE_REGS];
  logic                 mode_we;
  logic [3:0]           mode_idx;
  logic [7:0]           mode_wdata;
  logic                 pf_pending_q, pf_pending_d;

  logic                 clr_busy_q;
  logic [ADDR_BITS-1:0] clr_addr_q;

  logic                 ram_we, ram_re;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [7:0]           ram_wdata, ram_rdata;

  logic                 out_valid_q;
  logic [7:0]           read_value_q, value_d;
  logic                 irq_q, irq_d;

  assign in_ready_o = !clr_busy_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = vpri_pkg::op_e'(op_i);

  // A prefetch issued in the previous cycle has not yet reached the buffer register.
  assign rbuf_now = pf_pending_q ? ram_rdata : rbuf_q;
  assign addr_new = {data_i[HiW-1:0], addr_q[7:0]};

  always_comb begin
    addr_d       = addr_q;
    code_d       = code_q;
    second_d     = second_q;
    frame_d      = frame_q;
    line_cnt_d   = line_cnt_q;
    pf_pending_d = 1'b0;
    mode_we      = 1'b0;
    mode_idx     = data_i[3:0];
    mode_wdata   = addr_q[7:0];
    ram_we       = 1'b0;
    ram_waddr    = addr_q;
    ram_wdata    = data_i;
    ram_re       = 1'b0;
    ram_raddr    = addr_q;
    value_d      = '0;
    irq_d        = 1'b0;

    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (in_fire) begin
      unique case (op)
        vpri_pkg::OP_CTRL_WR: begin
          if (second_q) begin
            code_d = data_i[7:6];
            if (data_i[7:6] == vpri_pkg::CODE_VRAM_READ) begin
              ram_re       = 1'b1;
              ram_raddr    = addr_new;
              pf_pending_d = 1'b1;
              addr_d       = ADDR_BITS'(addr_new + 1'b1);
            end else begin
              addr_d = addr_new;
            end
            mode_we = (data_i[7:6] == vpri_pkg::CODE_REG_WRITE);
          end else begin
            addr_d = {addr_q[ADDR_BITS-1:8], data_i};
          end
          second_d = !second_q;
        end
        vpri_pkg::OP_CTRL_RD: begin
          second_d = 1'b0;
          value_d  = {frame_q, 7'b0};
          frame_d  = 1'b0;
        end
        vpri_pkg::OP_DATA_WR: begin
          second_d = 1'b0;
          ram_we   = (code_q != vpri_pkg::CODE_COLOUR);
          addr_d   = ADDR_BITS'(addr_q + 1'b1);
        end
        vpri_pkg::OP_DATA_RD: begin
          second_d     = 1'b0;
          value_d      = rbuf_now;
          ram_re       = 1'b1;
          pf_pending_d = 1'b1;
          addr_d       = ADDR_BITS'(addr_q + 1'b1);
        end
        vpri_pkg::OP_LINE_TICK: begin
          if (line_i == vpri_pkg::LINE_FRAME_IRQ &&
              mode_q[vpri_pkg::REG_MODE1][vpri_pkg::MODE1_FRAME_IE_BIT]) begin
            frame_d = 1'b1;
            irq_d   = 1'b1;
          end else begin
            irq_d = (line_cnt_q == 8'd0) &&
                    mode_q[vpri_pkg::REG_MODE0][vpri_pkg::MODE0_LINE_IE_BIT];
            if (line_i < vpri_pkg::LINE_ACTIVE_END) begin
              // The counter reloads when it would wrap below zero.
              line_cnt_d = (line_cnt_q == 8'd0) ? mode_q[vpri_pkg::REG_LINE_RELOAD]
                                                : 8'(line_cnt_q - 8'd1);
            end else if (line_i != vpri_pkg::LINE_ACTIVE_END) begin
              line_cnt_d = mode_q[vpri_pkg::REG_LINE_RELOAD];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      code_q       <= vpri_pkg::CODE_VRAM_READ;
      second_q     <= 1'b0;
      rbuf_q       <= '0;
      frame_q      <= 1'b0;
      line_cnt_q   <= vpri_pkg::LINE_COUNT_INIT;
      pf_pending_q <= 1'b0;
      clr_busy_q   <= 1'b1;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < vpri_pkg::NUM_MODE_REGS; i++) begin
        mode_q[i] <= '0;
      end
    end else begin
      addr_q       <= addr_d;
      code_q       <= code_d;
      second_q     <= second_d;
      rbuf_q       <= rbuf_now;
      frame_q      <= frame_d;
      line_cnt_q   <= line_cnt_d;
      pf_pending_q <= pf_pending_d;
      if (mode_we) begin
        mode_q[mode_idx] <= mode_wdata;
      end
      if (clr_busy_q) begin
        clr_addr_q <= ADDR_BITS'(clr_addr_q + 1'b1);
        if (clr_addr_q == {ADDR_BITS{1'b1}}) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_value_q <= value_d;
      irq_q        <= irq_d;
    end
  end

  vpri_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_video_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign irq_o        = irq_q;

  // No item may enter while the video memory is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !in_ready_o)
    else $error("item accepted during the video memory clearing pass");

  // A pending prefetch always stems from an item accepted in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pf_pending_q |-> $past(in_fire))
    else $error("read buffer refill without a preceding item");

  // Only a line tick can raise an interrupt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_fire && op_i != vpri_pkg::OP_LINE_TICK |=> !irq_q)
    else $error("interrupt raised by an item that is not a line tick");

  // Each item makes at most one video memory access.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("video memory read and write in the same cycle");

endmodule

@@ rtl/core/vpri_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module vpri_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
